// File: rtl/rbd_pkg.sv
// Shared constants, register indexes and channel widening functions for the box downscaler.
package rbd_pkg;

	localparam int MAX_FRAME_PIXELS_DEF = 131072;
	localparam int MAX_DIMENSION_DEF    = 1024;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 11;

	localparam logic [CFG_IDX_W-1:0] CFG_SRC_WIDTH  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SRC_HEIGHT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_DST_WIDTH  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_DST_HEIGHT = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_ROTATED    = 3'd4;

	localparam logic [CFG_DATA_W-1:0] RST_SRC_WIDTH  = 11'd320;
	localparam logic [CFG_DATA_W-1:0] RST_SRC_HEIGHT = 11'd240;
	localparam logic [CFG_DATA_W-1:0] RST_DST_WIDTH  = 11'd320;
	localparam logic [CFG_DATA_W-1:0] RST_DST_HEIGHT = 11'd240;

	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_EMIT = 1'b1;

	// c*255/31 by reciprocal: (c*255*33826) >> 20, exact for all 5-bit c
	function automatic logic [7:0] expand5(input logic [4:0] c);
		logic [12:0] x;
		logic [28:0] p;
		x = 13'(c) * 13'd255;
		p = 29'(x) * 29'd33826;
		return p[27:20];
	endfunction

	// c*255/63 by reciprocal: (c*255*16645) >> 20, exact for all 6-bit c
	function automatic logic [7:0] expand6(input logic [5:0] c);
		logic [13:0] x;
		logic [28:0] p;
		x = 14'(c) * 14'd255;
		p = 29'(x) * 29'd16645;
		return p[27:20];
	endfunction

endpackage

// File: rtl/rbd_div.sv
// Restoring divider, one quotient bit per cycle; caller guarantees num < den * 2^QW.
module rbd_div #(
	parameter int NW = 22,
	parameter int DW = 12,
	parameter int QW = 10
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	output logic [QW-1:0] quo,
	output logic          done
);
	localparam int IW = (NW > DW + QW) ? NW : DW + QW;
	localparam int CB = $clog2(QW + 1);

	logic [IW-1:0] rem_q;
	logic [IW-1:0] ds_q;
	logic [QW-1:0] quo_q;
	logic [CB-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;
	logic          ge;

	assign ge = rem_q >= ds_q;

	// iteration control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CB'(QW);
				done_q <= 1'b0;
			end else if (busy_q) begin
				cnt_q  <= cnt_q - 1'b1;
				done_q <= cnt_q == CB'(1);
				if (cnt_q == CB'(1)) begin
					busy_q <= 1'b0;
				end
			end else begin
				done_q <= 1'b0;
			end
		end
	end

	// datapath: compare, subtract, shift
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= IW'(num);
			ds_q  <= IW'(den) << (QW - 1);
			quo_q <= '0;
		end else if (busy_q) begin
			if (ge) begin
				rem_q <= rem_q - ds_q;
			end
			quo_q <= {quo_q[QW-2:0], ge};
			ds_q  <= ds_q >> 1;
		end
	end

	assign quo  = quo_q;
	assign done = done_q;

endmodule

// File: rtl/rbd_front.sv
// Front end: takes requests, tracks load position and output raster position, registers commands.
module rbd_front #(
	parameter int MAX_FRAME_PIXELS = rbd_pkg::MAX_FRAME_PIXELS_DEF,
	parameter int MAX_DIMENSION    = rbd_pkg::MAX_DIMENSION_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	output logic                                   in_ready,
	input  logic                                   operation,
	input  logic [15:0]                            pixel_value,
	input  logic [$clog2(MAX_FRAME_PIXELS+1)-1:0]  limit,
	input  logic [$clog2(MAX_DIMENSION+1)-1:0]     dw,
	input  logic [$clog2(MAX_DIMENSION+1)-1:0]     dh,
	output logic                                   cmd_valid,
	input  logic                                   cmd_ready,
	output logic                                   cmd_op,
	output logic [15:0]                            cmd_pixel,
	output logic [$clog2(MAX_FRAME_PIXELS)-1:0]    cmd_addr,
	output logic [$clog2(MAX_DIMENSION)-1:0]       cmd_x,
	output logic [$clog2(MAX_DIMENSION)-1:0]       cmd_y,
	output logic                                   cmd_last
);
	import rbd_pkg::*;

	localparam int DIMW = $clog2(MAX_DIMENSION + 1);
	localparam int CW   = $clog2(MAX_DIMENSION);
	localparam int LPW  = $clog2(MAX_FRAME_PIXELS + 1);
	localparam int AW   = $clog2(MAX_FRAME_PIXELS);

	logic            v_s1;
	logic            op_s1;
	logic [15:0]     pix_s1;
	logic [LPW-1:0]  load_pos_q;
	logic [CW-1:0]   col_q;
	logic [CW-1:0]   row_q;
	logic [LPW-1:0]  lp;
	logic [LPW-1:0]  lp_nxt;
	logic [CW-1:0]   x;
	logic [CW-1:0]   y;
	logic            col_end;
	logic            row_end;
	logic            fire;

	assign in_ready = !v_s1 || cmd_ready;
	assign fire     = v_s1 && cmd_ready;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ready) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			op_s1  <= operation;
			pix_s1 <= pixel_value;
		end
	end

	// positions, restarted when beyond the current frame
	always_comb begin
		lp      = (load_pos_q >= limit) ? '0 : load_pos_q;
		lp_nxt  = lp + 1'b1;
		x       = (DIMW'(col_q) >= dw) ? '0 : col_q;
		y       = (DIMW'(row_q) >= dh) ? '0 : row_q;
		col_end = (DIMW'(x) + 1'b1) >= dw;
		row_end = (DIMW'(y) + 1'b1) >= dh;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_pos_q <= '0;
			col_q      <= '0;
			row_q      <= '0;
		end else if (fire) begin
			if (op_s1 == OP_LOAD) begin
				load_pos_q <= (lp_nxt >= limit) ? '0 : lp_nxt;
			end else if (col_end) begin
				col_q <= '0;
				row_q <= row_end ? '0 : y + 1'b1;
			end else begin
				col_q <= x + 1'b1;
				row_q <= y;
			end
		end
	end

	assign cmd_valid = v_s1;
	assign cmd_op    = op_s1;
	assign cmd_pixel = pix_s1;
	assign cmd_addr  = lp[AW-1:0];
	assign cmd_x     = x;
	assign cmd_y     = y;
	assign cmd_last  = col_end && row_end;

endmodule

// File: rtl/rbd_back.sv
// Back end: command queue, frame store, window scan, averaging and result register.
module rbd_back #(
	parameter int MAX_FRAME_PIXELS = rbd_pkg::MAX_FRAME_PIXELS_DEF,
	parameter int MAX_DIMENSION    = rbd_pkg::MAX_DIMENSION_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cmd_valid,
	output logic                                 cmd_ready,
	input  logic                                 cmd_op,
	input  logic [15:0]                          cmd_pixel,
	input  logic [$clog2(MAX_FRAME_PIXELS)-1:0]  cmd_addr,
	input  logic [$clog2(MAX_DIMENSION)-1:0]     cmd_x,
	input  logic [$clog2(MAX_DIMENSION)-1:0]     cmd_y,
	input  logic                                 cmd_last,
	input  logic [$clog2(MAX_DIMENSION+1)-1:0]   sw,
	input  logic [$clog2(MAX_DIMENSION+1)-1:0]   sh,
	input  logic [$clog2(MAX_DIMENSION+1)-1:0]   dw,
	input  logic [$clog2(MAX_DIMENSION+1)-1:0]   dh,
	input  logic                                 pass,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic [15:0]                          out_pixel,
	output logic                                 frame_end
);
	import rbd_pkg::*;

	localparam int DIMW = $clog2(MAX_DIMENSION + 1);
	localparam int CW   = $clog2(MAX_DIMENSION);
	localparam int AW   = $clog2(MAX_FRAME_PIXELS);
	localparam int LPW  = $clog2(MAX_FRAME_PIXELS + 1);
	localparam int AXW0 = $clog2(MAX_DIMENSION * MAX_DIMENSION + MAX_DIMENSION);
	localparam int AXW  = (AXW0 > LPW) ? AXW0 : LPW;
	localparam int NW   = 2 * DIMW;
	localparam int CNTW = 2 * CW;
	localparam int SUMW = CNTW + 8;
	localparam int QD   = 4;
	localparam int QPW  = 2;
	localparam int QCW  = 3;
	localparam int EW   = 1 + 16 + AW + CW + CW + 1;

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_MUL   = 4'd1;
	localparam logic [3:0] ST_PADDR = 4'd2;
	localparam logic [3:0] ST_PWAIT = 4'd3;
	localparam logic [3:0] ST_DIV   = 4'd4;
	localparam logic [3:0] ST_DWAIT = 4'd5;
	localparam logic [3:0] ST_CNT   = 4'd6;
	localparam logic [3:0] ST_SCAN  = 4'd7;
	localparam logic [3:0] ST_DRAIN = 4'd8;
	localparam logic [3:0] ST_CDIV  = 4'd9;
	localparam logic [3:0] ST_CWAIT = 4'd10;
	localparam logic [3:0] ST_OUT   = 4'd11;

	// command queue
	logic [EW-1:0]   q_mem_q [QD];
	logic [QPW-1:0]  wr_ptr_q;
	logic [QPW-1:0]  rd_ptr_q;
	logic [QCW-1:0]  q_cnt_q;
	logic [EW-1:0]   head;
	logic            push;
	logic            pop;
	logic            h_op;
	logic [15:0]     h_pix;
	logic [AW-1:0]   h_addr;
	logic [CW-1:0]   h_x;
	logic [CW-1:0]   h_y;
	logic            h_last;

	// sequencer
	logic [3:0]      st_q;
	logic [CW-1:0]   x_q;
	logic [CW-1:0]   y_q;
	logic            last_q;
	logic [NW-1:0]   nx1_q;
	logic [NW-1:0]   nx2_q;
	logic [NW-1:0]   ny1_q;
	logic [NW-1:0]   ny2_q;
	logic [AXW-1:0]  pbase_q;
	logic [AXW-1:0]  base_q;
	logic [CW-1:0]   j_q;
	logic [CW-1:0]   i_q;
	logic [CNTW-1:0] count_q;
	logic [SUMW-1:0] sum_r_q;
	logic [SUMW-1:0] sum_g_q;
	logic [SUMW-1:0] sum_b_q;
	logic [15:0]     res_q;
	logic            out_valid_q;
	logic [15:0]     out_pixel_q;
	logic            frame_end_q;

	// divider results
	logic [CW-1:0]   x1;
	logic [CW-1:0]   x2;
	logic [CW-1:0]   y1;
	logic [CW-1:0]   y2;
	logic            dn_x1;
	logic            dn_x2;
	logic            dn_y1;
	logic            dn_y2;
	logic [7:0]      q_r;
	logic [7:0]      q_g;
	logic [7:0]      q_b;
	logic            dn_r;
	logic            dn_g;
	logic            dn_b;
	logic            cdiv_start;
	logic            cnt_start;
	logic [DIMW:0]   den_x;
	logic [DIMW:0]   den_y;

	// read pipeline
	logic [15:0]     mem_q [MAX_FRAME_PIXELS];
	logic [15:0]     mem_rd_s1;
	logic            rdv_s1;
	logic            oob_s1;
	logic            rdv_s2;
	logic [7:0]      er_s2;
	logic [7:0]      eg_s2;
	logic [7:0]      eb_s2;

	logic [CW-1:0]   wc;
	logic [CW-1:0]   hc;
	logic [CNTW-1:0] cnt_prod;
	logic [AXW-1:0]  scan_addr;
	logic [AXW-1:0]  paddr;
	logic            scan_oob;
	logic            p_oob;
	logic            rd_en;
	logic [AW-1:0]   rd_addr;
	logic            out_free;
	logic            row_done;
	logic            col_done;

	assign cmd_ready = q_cnt_q != QCW'(QD);
	assign push      = cmd_valid && cmd_ready;
	assign pop       = (st_q == ST_IDLE) && (q_cnt_q != '0);
	assign head      = q_mem_q[rd_ptr_q];
	assign {h_op, h_pix, h_addr, h_x, h_y, h_last} = head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			q_cnt_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			q_cnt_q <= q_cnt_q + QCW'(push) - QCW'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			q_mem_q[wr_ptr_q] <= {cmd_op, cmd_pixel, cmd_addr, cmd_x, cmd_y, cmd_last};
		end
	end

	// window bounds: floor(x*sw/(dw+1)) and friends
	assign den_x      = (DIMW + 1)'(dw) + 1'b1;
	assign den_y      = (DIMW + 1)'(dh) + 1'b1;
	assign cnt_start  = st_q == ST_DIV;
	assign cdiv_start = st_q == ST_CDIV;

	rbd_div #(.NW(NW), .DW(DIMW + 1), .QW(CW)) u_div_x1 (
		.clk(clk), .arst_n(arst_n), .start(cnt_start), .num(nx1_q), .den(den_x),
		.quo(x1), .done(dn_x1));
	rbd_div #(.NW(NW), .DW(DIMW + 1), .QW(CW)) u_div_x2 (
		.clk(clk), .arst_n(arst_n), .start(cnt_start), .num(nx2_q), .den(den_x),
		.quo(x2), .done(dn_x2));
	rbd_div #(.NW(NW), .DW(DIMW + 1), .QW(CW)) u_div_y1 (
		.clk(clk), .arst_n(arst_n), .start(cnt_start), .num(ny1_q), .den(den_y),
		.quo(y1), .done(dn_y1));
	rbd_div #(.NW(NW), .DW(DIMW + 1), .QW(CW)) u_div_y2 (
		.clk(clk), .arst_n(arst_n), .start(cnt_start), .num(ny2_q), .den(den_y),
		.quo(y2), .done(dn_y2));

	// channel averages: quotient never exceeds 255
	rbd_div #(.NW(SUMW), .DW(CNTW), .QW(8)) u_div_r (
		.clk(clk), .arst_n(arst_n), .start(cdiv_start), .num(sum_r_q), .den(count_q),
		.quo(q_r), .done(dn_r));
	rbd_div #(.NW(SUMW), .DW(CNTW), .QW(8)) u_div_g (
		.clk(clk), .arst_n(arst_n), .start(cdiv_start), .num(sum_g_q), .den(count_q),
		.quo(q_g), .done(dn_g));
	rbd_div #(.NW(SUMW), .DW(CNTW), .QW(8)) u_div_b (
		.clk(clk), .arst_n(arst_n), .start(cdiv_start), .num(sum_b_q), .den(count_q),
		.quo(q_b), .done(dn_b));

	// addresses and window sizes
	always_comb begin
		wc        = x2 - x1;
		hc        = y2 - y1;
		cnt_prod  = CNTW'(wc) * CNTW'(hc);
		scan_addr = base_q + AXW'(j_q);
		paddr     = pbase_q + AXW'(x_q);
		scan_oob  = scan_addr >= AXW'(MAX_FRAME_PIXELS);
		p_oob     = paddr >= AXW'(MAX_FRAME_PIXELS);
		col_done  = (j_q + 1'b1) == x2;
		row_done  = (i_q + 1'b1) == y2;
		rd_en     = ((st_q == ST_SCAN) && !scan_oob) || ((st_q == ST_PADDR) && !p_oob);
		rd_addr   = (st_q == ST_SCAN) ? scan_addr[AW-1:0] : paddr[AW-1:0];
		out_free  = !out_valid_q || out_ready;
	end

	// frame store
	always_ff @(posedge clk) begin
		if (pop && (h_op == OP_LOAD)) begin
			mem_q[h_addr] <= h_pix;
		end
		if (rd_en) begin
			mem_rd_s1 <= mem_q[rd_addr];
		end
	end

	// read pipeline: widen channels, then accumulate
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rdv_s1 <= 1'b0;
			rdv_s2 <= 1'b0;
		end else begin
			rdv_s1 <= st_q == ST_SCAN;
			rdv_s2 <= rdv_s1;
		end
	end

	always_ff @(posedge clk) begin
		oob_s1 <= (st_q == ST_SCAN) ? scan_oob : p_oob;
		if (rdv_s1) begin
			er_s2 <= oob_s1 ? 8'd0 : expand5(mem_rd_s1[15:11]);
			eg_s2 <= oob_s1 ? 8'd0 : expand6(mem_rd_s1[10:5]);
			eb_s2 <= oob_s1 ? 8'd0 : expand5(mem_rd_s1[4:0]);
		end
		if (st_q == ST_CNT) begin
			sum_r_q <= '0;
			sum_g_q <= '0;
			sum_b_q <= '0;
		end else if (rdv_s2) begin
			sum_r_q <= sum_r_q + SUMW'(er_s2);
			sum_g_q <= sum_g_q + SUMW'(eg_s2);
			sum_b_q <= sum_b_q + SUMW'(eb_s2);
		end
	end

	// sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if ((st_q == ST_OUT) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (st_q)
				ST_IDLE: begin
					if (pop && (h_op == OP_EMIT)) begin
						st_q <= ST_MUL;
					end
				end
				ST_MUL:   st_q <= pass ? ST_PADDR : ST_DIV;
				ST_PADDR: st_q <= ST_PWAIT;
				ST_PWAIT: st_q <= ST_OUT;
				ST_DIV:   st_q <= ST_DWAIT;
				ST_DWAIT: begin
					if (dn_x1 && dn_x2 && dn_y1 && dn_y2) begin
						st_q <= ST_CNT;
					end
				end
				ST_CNT: st_q <= (cnt_prod == '0) ? ST_OUT : ST_SCAN;
				ST_SCAN: begin
					if (col_done && row_done) begin
						st_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (!rdv_s1 && !rdv_s2) begin
						st_q <= ST_CDIV;
					end
				end
				ST_CDIV: st_q <= ST_CWAIT;
				ST_CWAIT: begin
					if (dn_r && dn_g && dn_b) begin
						st_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_free) begin
						st_q <= ST_IDLE;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	// sequencer datapath
	always_ff @(posedge clk) begin
		case (st_q)
			ST_IDLE: begin
				x_q    <= h_x;
				y_q    <= h_y;
				last_q <= h_last;
			end
			ST_MUL: begin
				nx1_q   <= NW'(x_q) * NW'(sw);
				nx2_q   <= (NW'(x_q) + 1'b1) * NW'(sw);
				ny1_q   <= NW'(y_q) * NW'(sh);
				ny2_q   <= (NW'(y_q) + 1'b1) * NW'(sh);
				pbase_q <= AXW'(y_q) * AXW'(sw);
			end
			ST_PWAIT: res_q <= oob_s1 ? 16'd0 : mem_rd_s1;
			ST_CNT: begin
				count_q <= cnt_prod;
				base_q  <= AXW'(y1) * AXW'(sw);
				j_q     <= x1;
				i_q     <= y1;
				res_q   <= 16'd0;
			end
			ST_SCAN: begin
				if (col_done) begin
					j_q    <= x1;
					i_q    <= i_q + 1'b1;
					base_q <= base_q + AXW'(sw);
				end else begin
					j_q <= j_q + 1'b1;
				end
			end
			ST_CWAIT: res_q <= {q_r[7:3], q_g[7:2], q_b[7:3]};
			ST_OUT: begin
				if (out_free) begin
					out_pixel_q <= res_q;
					frame_end_q <= last_q;
				end
			end
			default: ;
		endcase
	end

	assign out_valid = out_valid_q;
	assign out_pixel = out_pixel_q;
	assign frame_end = frame_end_q;

	a_q_bound: assert property (@(posedge clk) disable iff (!arst_n)
		q_cnt_q <= QCW'(QD))
		else $error("command queue overfilled");

	a_scan_in_window: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_SCAN) |-> ((i_q < y2) && (j_q < x2) && (j_q >= x1)))
		else $error("scan position left the window");

	a_cdiv_lockstep: assert property (@(posedge clk) disable iff (!arst_n)
		dn_r |-> (dn_g && dn_b))
		else $error("channel dividers out of step");

	a_drain_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_CDIV) |-> (!rdv_s1 && !rdv_s2))
		else $error("averaging started with reads in flight");

endmodule

// File: rtl/rgb565_box_downscaler_core.sv
// Top level: configuration registers, derived frame geometry, front and back ends.
// Load request: front register, command queue, store write; one load per cycle sustained
//   while no emit runs. Emit, equal dimensions: queue wait, MUL, PADDR, PWAIT, OUT.
// Emit, scaled: MUL, bound dividers, CNT, scan of the W by H window, drain, channel
//   dividers, OUT (empty window: CNT to OUT); single store read port, bit-serial dividers.
// Reset clears configuration, positions, queue and handshakes; the frame store is not cleared.
module rgb565_box_downscaler_core #(
	parameter int MAX_FRAME_PIXELS = rbd_pkg::MAX_FRAME_PIXELS_DEF,
	parameter int MAX_DIMENSION    = rbd_pkg::MAX_DIMENSION_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_wen,
	input  logic [rbd_pkg::CFG_IDX_W-1:0]   cfg_idx,
	input  logic [rbd_pkg::CFG_DATA_W-1:0]  cfg_wdata,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic                            operation,
	input  logic [15:0]                     pixel_value,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [15:0]                     out_pixel,
	output logic                            frame_end
);
	import rbd_pkg::*;

	localparam int DIMW = $clog2(MAX_DIMENSION + 1);
	localparam int CW   = $clog2(MAX_DIMENSION);
	localparam int AW   = $clog2(MAX_FRAME_PIXELS);
	localparam int LPW  = $clog2(MAX_FRAME_PIXELS + 1);
	localparam int EXW  = (DIMW > CFG_DATA_W) ? DIMW : CFG_DATA_W;
	localparam int PW0  = 2 * DIMW;
	localparam int PW   = (PW0 > LPW) ? PW0 : LPW;

	logic [CFG_DATA_W-1:0] src_w_q;
	logic [CFG_DATA_W-1:0] src_h_q;
	logic [CFG_DATA_W-1:0] dst_w_q;
	logic [CFG_DATA_W-1:0] dst_h_q;
	logic                  rot_q;
	logic [DIMW-1:0]       sw_c;
	logic [DIMW-1:0]       sh_c;
	logic [DIMW-1:0]       dw_c;
	logic [DIMW-1:0]       dh_c;
	logic [PW-1:0]         area;
	logic [DIMW-1:0]       sw_q;
	logic [DIMW-1:0]       sh_q;
	logic [DIMW-1:0]       dw_q;
	logic [DIMW-1:0]       dh_q;
	logic [LPW-1:0]        limit_q;
	logic                  pass_q;

	logic                  cmd_valid;
	logic                  cmd_ready;
	logic                  cmd_op;
	logic [15:0]           cmd_pixel;
	logic [AW-1:0]         cmd_addr;
	logic [CW-1:0]         cmd_x;
	logic [CW-1:0]         cmd_y;
	logic                  cmd_last;

	// zero reads as one, oversize as the maximum
	function automatic logic [DIMW-1:0] clamp_dim(input logic [CFG_DATA_W-1:0] v);
		logic [EXW-1:0] e;
		e = EXW'(v);
		if (e == '0) begin
			return DIMW'(1);
		end else if (e > EXW'(MAX_DIMENSION)) begin
			return DIMW'(MAX_DIMENSION);
		end
		return DIMW'(e);
	endfunction

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_w_q <= RST_SRC_WIDTH;
			src_h_q <= RST_SRC_HEIGHT;
			dst_w_q <= RST_DST_WIDTH;
			dst_h_q <= RST_DST_HEIGHT;
			rot_q   <= 1'b0;
		end else if (cfg_wen) begin
			case (cfg_idx)
				CFG_SRC_WIDTH:  src_w_q <= cfg_wdata;
				CFG_SRC_HEIGHT: src_h_q <= cfg_wdata;
				CFG_DST_WIDTH:  dst_w_q <= cfg_wdata;
				CFG_DST_HEIGHT: dst_h_q <= cfg_wdata;
				CFG_ROTATED:    rot_q   <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	// effective geometry after the rotation swap
	always_comb begin
		sw_c = clamp_dim(rot_q ? src_h_q : src_w_q);
		sh_c = clamp_dim(rot_q ? src_w_q : src_h_q);
		dw_c = clamp_dim(rot_q ? dst_h_q : dst_w_q);
		dh_c = clamp_dim(rot_q ? dst_w_q : dst_h_q);
		area = PW'(sw_c) * PW'(sh_c);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sw_q    <= '0;
			sh_q    <= '0;
			dw_q    <= '0;
			dh_q    <= '0;
			limit_q <= '0;
			pass_q  <= 1'b0;
		end else begin
			sw_q    <= sw_c;
			sh_q    <= sh_c;
			dw_q    <= dw_c;
			dh_q    <= dh_c;
			limit_q <= (area > PW'(MAX_FRAME_PIXELS)) ? LPW'(MAX_FRAME_PIXELS) : LPW'(area);
			pass_q  <= (sw_c == dw_c) && (sh_c == dh_c);
		end
	end

	rbd_front #(
		.MAX_FRAME_PIXELS(MAX_FRAME_PIXELS),
		.MAX_DIMENSION(MAX_DIMENSION)
	) u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.operation(operation), .pixel_value(pixel_value),
		.limit(limit_q), .dw(dw_q), .dh(dh_q),
		.cmd_valid(cmd_valid), .cmd_ready(cmd_ready),
		.cmd_op(cmd_op), .cmd_pixel(cmd_pixel), .cmd_addr(cmd_addr),
		.cmd_x(cmd_x), .cmd_y(cmd_y), .cmd_last(cmd_last)
	);

	rbd_back #(
		.MAX_FRAME_PIXELS(MAX_FRAME_PIXELS),
		.MAX_DIMENSION(MAX_DIMENSION)
	) u_back (
		.clk(clk), .arst_n(arst_n),
		.cmd_valid(cmd_valid), .cmd_ready(cmd_ready),
		.cmd_op(cmd_op), .cmd_pixel(cmd_pixel), .cmd_addr(cmd_addr),
		.cmd_x(cmd_x), .cmd_y(cmd_y), .cmd_last(cmd_last),
		.sw(sw_q), .sh(sh_q), .dw(dw_q), .dh(dh_q), .pass(pass_q),
		.out_valid(out_valid), .out_ready(out_ready),
		.out_pixel(out_pixel), .frame_end(frame_end)
	);

endmodule

// File: tb/tb.sv
// Testbench for the RGB565 box downscaler: directed and random requests against a local predictor.
module tb;
	import rbd_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int STORE_DEPTH = 131072;
	localparam int DIM_MAX     = 1024;
	localparam int DRAIN_WAIT  = 64;
	localparam int HOLD_CYCLES = 400;

	typedef struct packed {
		logic [15:0] pixel;
		logic        last;
	} out_pix_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_wen;
	logic [CFG_IDX_W-1:0]  cfg_idx;
	logic [CFG_DATA_W-1:0] cfg_wdata;
	logic                  in_valid;
	logic                  in_ready;
	logic                  operation;
	logic [15:0]           pixel_value;
	logic                  out_valid;
	logic                  out_ready;
	logic [15:0]           out_pixel;
	logic                  frame_end;

	// predictor state
	logic [15:0]     shadow_store [0:STORE_DEPTH-1];
	int unsigned     load_pos;
	int unsigned     col_pos;
	int unsigned     row_pos;
	logic [10:0]     reg_src_w, reg_src_h, reg_dst_w, reg_dst_h;
	logic            reg_rot;
	out_pix_t        pending_pixels [$];

	int  error_count;
	int  accepted_count;
	int  send_idle_pct;
	int  recv_stall_pct;
	bit  hold_req;

	rgb565_box_downscaler_core u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wen     (cfg_wen),
		.cfg_idx     (cfg_idx),
		.cfg_wdata   (cfg_wdata),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.operation   (operation),
		.pixel_value (pixel_value),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_pixel   (out_pixel),
		.frame_end   (frame_end)
	);

	// clock
	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	function automatic int unsigned clamp_dim(input logic [10:0] v);
		if (v == 0)
			return 1;
		if (v > DIM_MAX)
			return DIM_MAX;
		return v;
	endfunction

	function automatic int unsigned eff_sw();
		return clamp_dim(reg_rot ? reg_src_h : reg_src_w);
	endfunction
	function automatic int unsigned eff_sh();
		return clamp_dim(reg_rot ? reg_src_w : reg_src_h);
	endfunction
	function automatic int unsigned eff_dw();
		return clamp_dim(reg_rot ? reg_dst_h : reg_dst_w);
	endfunction
	function automatic int unsigned eff_dh();
		return clamp_dim(reg_rot ? reg_dst_w : reg_dst_h);
	endfunction

	function automatic logic [15:0] fetch_src(input longint unsigned addr);
		if (addr >= STORE_DEPTH)
			return 16'h0000;
		return shadow_store[addr];
	endfunction

	// store one pixel at the load position, wrapping at the frame size
	function automatic void predict_load(input logic [15:0] pix);
		longint unsigned lim;
		lim = longint'(eff_sw()) * eff_sh();
		if (lim > STORE_DEPTH)
			lim = STORE_DEPTH;
		if (load_pos >= lim)
			load_pos = 0;
		shadow_store[load_pos] = pix;
		load_pos++;
		if (load_pos >= lim)
			load_pos = 0;
	endfunction

	// box average of the window, or the source pixel when dimensions match, for the current output position
	function automatic out_pix_t predict_emit();
		int unsigned     sw, sh, dw, dh, x, y, x1, x2, y1, y2;
		longint unsigned cnt, rs, gs, bs;
		logic [15:0]     c;
		out_pix_t        res;
		sw = eff_sw();
		sh = eff_sh();
		dw = eff_dw();
		dh = eff_dh();
		if (col_pos >= dw)
			col_pos = 0;
		if (row_pos >= dh)
			row_pos = 0;
		x = col_pos;
		y = row_pos;
		if (sw == dw && sh == dh) begin
			res.pixel = fetch_src(longint'(y) * sw + x);
		end else begin
			x1 = 32'((longint'(x) * sw) / (dw + 1));
			x2 = 32'((longint'(x + 1) * sw) / (dw + 1));
			y1 = 32'((longint'(y) * sh) / (dh + 1));
			y2 = 32'((longint'(y + 1) * sh) / (dh + 1));
			cnt = longint'(x2 - x1) * (y2 - y1);
			if (cnt == 0) begin
				res.pixel = 16'h0000;
			end else begin
				rs = 0;
				gs = 0;
				bs = 0;
				for (int unsigned i = y1; i < y2; i++) begin
					for (int unsigned j = x1; j < x2; j++) begin
						c = fetch_src(longint'(i) * sw + j);
						rs += (int'(c[15:11]) * 255) / 31;
						gs += (int'(c[10:5]) * 255) / 63;
						bs += (int'(c[4:0]) * 255) / 31;
					end
				end
				rs /= cnt;
				gs /= cnt;
				bs /= cnt;
				res.pixel = {rs[7:3], gs[7:2], bs[7:3]};
			end
		end
		res.last = 1'b0;
		if (x + 1 >= dw) begin
			col_pos = 0;
			if (y + 1 >= dh) begin
				row_pos = 0;
				res.last = 1'b1;
			end else begin
				row_pos = y + 1;
			end
		end else begin
			col_pos = x + 1;
		end
		return res;
	endfunction

	// receiver: random stalls, plus a long hold-off on request
	always @(posedge clk) begin
		int hold_left;
		if (hold_req) begin
			hold_req = 1'b0;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// result checker
	always @(posedge clk) begin
		out_pix_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_pixels.size() == 0) begin
				$display("%0t: unexpected result pixel=%h frame_end=%b", $time,
					out_pixel, frame_end);
				error_count++;
			end else begin
				want = pending_pixels.pop_front();
				if (out_pixel !== want.pixel) begin
					$display("%0t: out_pixel expected %h actual %h", $time, want.pixel, out_pixel);
					error_count++;
				end
				if (frame_end !== want.last) begin
					$display("%0t: frame_end expected %b actual %b", $time, want.last, frame_end);
					error_count++;
				end
			end
		end
	end

	// one request on the input channel; called and returns at a rising edge
	task automatic send_req(input logic op, input logic [15:0] pix);
		if ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(99) < send_idle_pct);
		end
		in_valid    <= 1'b1;
		operation   <= op;
		pixel_value <= pix;
		do
			@(posedge clk);
		while (!in_ready);
		accepted_count++;
		if (op == OP_LOAD)
			predict_load(pix);
		else
			pending_pixels.push_back(predict_emit());
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (pending_pixels.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	// drives one register write; the caller drops the enable after the last one
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [10:0] val);
		cfg_wen   <= 1'b1;
		cfg_idx   <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		case (idx)
			CFG_SRC_WIDTH:  reg_src_w = val;
			CFG_SRC_HEIGHT: reg_src_h = val;
			CFG_DST_WIDTH:  reg_dst_w = val;
			CFG_DST_HEIGHT: reg_dst_h = val;
			CFG_ROTATED:    reg_rot = val[0];
			default: ;
		endcase
	endtask

	task automatic set_geometry(input logic [10:0] sw, input logic [10:0] sh,
		input logic [10:0] dw, input logic [10:0] dh, input logic rot);
		drain();
		write_reg(CFG_SRC_WIDTH, sw);
		write_reg(CFG_SRC_HEIGHT, sh);
		write_reg(CFG_DST_WIDTH, dw);
		write_reg(CFG_DST_HEIGHT, dh);
		write_reg(CFG_ROTATED, {10'd0, rot});
		cfg_wen <= 1'b0;
	endtask

	// fill the whole source frame so no emit reads an unwritten entry
	task automatic fill_frame();
		int unsigned n;
		n = eff_sw() * eff_sh();
		repeat (n) send_req(OP_LOAD, 16'($urandom));
	endtask

	task automatic test_passthrough();
		set_geometry(11'd2, 11'd2, 11'd2, 11'd2, 1'b0);
		send_req(OP_LOAD, 16'h0000);
		send_req(OP_LOAD, 16'hFFFF);
		send_req(OP_LOAD, 16'hF800);
		send_req(OP_LOAD, 16'h07FF);
		repeat (4) send_req(OP_EMIT, 16'hFFFF);
	endtask

	task automatic test_rotated_scale();
		set_geometry(11'd4, 11'd2, 11'd1, 11'd1, 1'b1);
		send_req(OP_LOAD, 16'hFFFF);
		send_req(OP_LOAD, 16'h0000);
		repeat (6) send_req(OP_LOAD, 16'($urandom));
		repeat (2) send_req(OP_EMIT, 16'h0000);
	endtask

	// windows narrower than one source pixel are empty
	task automatic test_empty_window();
		set_geometry(11'd1, 11'd1, 11'd3, 11'd1, 1'b0);
		send_req(OP_LOAD, 16'hABCD);
		repeat (3) send_req(OP_EMIT, 16'h0000);
	endtask

	// zero dimensions behave as one
	task automatic test_zero_dims();
		set_geometry(11'd0, 11'd0, 11'd0, 11'd0, 1'b0);
		send_req(OP_LOAD, 16'h5A5A);
		send_req(OP_EMIT, 16'h0000);
	endtask

	// oversized widths clamp; rows past the store read as black
	task automatic test_beyond_store();
		set_geometry(11'd1, 11'd3, 11'd1, 11'd3, 1'b0);
		fill_frame();
		while (!(row_pos == 2 && col_pos == 0))
			send_req(OP_EMIT, 16'h0000);
		set_geometry(11'd2047, 11'd1024, 11'd1024, 11'd3, 1'b0);
		repeat (3) send_req(OP_EMIT, 16'h0000);
	endtask

	// receiver held off while emits keep coming, then a full drain
	task automatic test_backpressure();
		set_geometry(11'd4, 11'd4, 11'd4, 11'd4, 1'b0);
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		fill_frame();
		hold_req = 1'b1;
		repeat (40) send_req(OP_EMIT, 16'h0000);
		drain();
	endtask

	task automatic test_random(input int target);
		int frame_no;
		int n_ops;
		logic [10:0] sw, sh, dw, dh;
		frame_no = 0;
		while (accepted_count < target) begin
			sw = 11'($urandom_range(12));
			sh = 11'($urandom_range(12));
			dw = 11'($urandom_range(12));
			dh = 11'($urandom_range(12));
			if ($urandom_range(3) == 0) begin
				dw = sw;
				dh = sh;
			end
			set_geometry(sw, sh, dw, dh, 1'($urandom));
			case (frame_no % 5)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 58; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 58; end
				3: begin send_idle_pct = 6;  recv_stall_pct = 6;  end
				default: begin send_idle_pct = 58; recv_stall_pct = 58; end
			endcase
			fill_frame();
			n_ops = $urandom_range(4, 2 * eff_dw() * eff_dh() + 4);
			repeat (n_ops) begin
				if ($urandom_range(99) < 80)
					send_req(OP_EMIT, 16'($urandom));
				else
					send_req(OP_LOAD, 16'($urandom));
			end
			frame_no++;
		end
	endtask

	initial begin
		error_count    = 0;
		accepted_count = 0;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		hold_req       = 1'b0;
		load_pos       = 0;
		col_pos        = 0;
		row_pos        = 0;
		reg_src_w      = RST_SRC_WIDTH;
		reg_src_h      = RST_SRC_HEIGHT;
		reg_dst_w      = RST_DST_WIDTH;
		reg_dst_h      = RST_DST_HEIGHT;
		reg_rot        = 1'b0;
		arst_n      <= 1'b0;
		cfg_wen     <= 1'b0;
		cfg_idx     <= CFG_SRC_WIDTH;
		cfg_wdata   <= '0;
		in_valid    <= 1'b0;
		operation   <= OP_LOAD;
		pixel_value <= 16'h0000;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_passthrough();
		test_rotated_scale();
		test_empty_window();
		test_zero_dims();
		test_beyond_store();
		test_backpressure();
		test_random(1900);
		drain();

		if (error_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	// watchdog
	initial begin
		#20_000_000;
		$display("DONE: errors detected");
		$finish;
	end

endmodule

// File: sim.f
rtl/rbd_pkg.sv
rtl/rbd_div.sv
rtl/rbd_front.sv
rtl/rbd_back.sv
rtl/rgb565_box_downscaler_core.sv
tb/tb.sv
